>>> hw/rtl/lfrt_pkg.sv
// Package for the longest free run tracker: sizes, controller states,
// the controller/datapath command and status structs, and the run-merge function.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package lfrt_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int MAX_TOP       = MAX_POSITIONS - 1;
  localparam int POS_W         = 10;
  localparam int TOP_W         = 10;
  localparam int RUN_W         = 11;
  localparam int DATA_IN_W     = 16;
  localparam int DATA_OUT_W    = 16;
  localparam int WORD_W        = 32;
  localparam int WORD_LOG      = $clog2(WORD_W);
  localparam int NUM_WORDS     = MAX_POSITIONS / WORD_W;
  localparam int ADDR_W        = $clog2(NUM_WORDS);
  localparam int MAP_W         = $clog2(MAX_POSITIONS);
  localparam int SEG_W         = WORD_LOG + 1;

  localparam logic [TOP_W-1:0] TOP_RESET = TOP_W'(1023);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              update;
    logic              scan_rd;
    logic [ADDR_W-1:0] scan_addr;
    logic              load_out;
  } lfrt_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } lfrt_status_t;

  // Run summary of a segment: all free, free run at the low end,
  // free run at the high end, and longest free run inside.
  typedef struct packed {
    logic             full;
    logic [SEG_W-1:0] pre;
    logic [SEG_W-1:0] suf;
    logic [SEG_W-1:0] best;
  } seg_t;

  function automatic seg_t seg_join(seg_t lo, seg_t hi);
    seg_t             r;
    logic [SEG_W-1:0] mid;
    logic [SEG_W-1:0] m;
    r.full = lo.full & hi.full;
    r.pre  = lo.full ? SEG_W'(lo.pre + hi.pre) : lo.pre;
    r.suf  = hi.full ? SEG_W'(hi.suf + lo.suf) : hi.suf;
    mid    = SEG_W'(lo.suf + hi.pre);
    m      = (lo.best > hi.best) ? lo.best : hi.best;
    r.best = (mid > m) ? mid : m;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lfrt_ctrl.sv
// Controller of the longest free run tracker: sequences lookup, update,
// word scan and result hand-off. Depends on lfrt_pkg.
`default_nettype none

module lfrt_ctrl
  import lfrt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire lfrt_status_t status,
  output lfrt_cmd_t         cmd
);

  state_t            state;
  state_t            state_next;
  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.scan_addr = cnt;
    s_tready      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        cnt_next   = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cnt_next    = ADDR_W'(cnt + 1'b1);
        if (cnt == ADDR_W'(NUM_WORDS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfrt_datapath.sv
// Datapath of the longest free run tracker: removal bitmap memory, range
// register, word summary tree, run accumulator and output register.
// Depends on lfrt_pkg.
`default_nettype none

module lfrt_datapath
  import lfrt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [POS_W-1:0] pos_in,
  input  wire logic             cfg_we,
  input  wire logic [TOP_W-1:0] cfg_top,
  input  wire lfrt_cmd_t        cmd,
  output lfrt_status_t          status,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic [RUN_W-1:0]      out_run,
  output logic                  out_rej
);

  logic [WORD_W-1:0] mem [0:NUM_WORDS-1];
  logic [NUM_WORDS-1:0] row_valid;

  logic [TOP_W-1:0]  top;
  logic [MAP_W-1:0]  eff_top;
  logic [POS_W-1:0]  pos;
  logic              rej;
  logic [WORD_W-1:0] rd_word;
  logic              rd_ok;
  logic [WORD_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_addr_q;
  logic              rd_en;
  logic              scan_v;
  logic              sum_v;
  seg_t              summary;
  seg_t              word_seg;
  logic [WORD_W-1:0] above;
  logic [WORD_W-1:0] free_bits;
  logic [RUN_W-1:0]  cur;
  logic [RUN_W-1:0]  best;
  logic [RUN_W-1:0]  cur_next;
  logic [RUN_W-1:0]  best_next;
  logic [RUN_W-1:0]  cand;
  logic [RUN_W-1:0]  wbest;
  logic [ADDR_W-1:0] pos_word;
  logic [WORD_LOG-1:0] pos_bit;
  logic              rej_now;
  logic              removed_bit;
  seg_t              tree [0:WORD_LOG][0:WORD_W-1];

  // Marks outside the map cannot exist, so the range is clipped to it.
  assign eff_top = (32'(top) > MAX_TOP) ? MAP_W'(MAX_TOP) : MAP_W'(top);

  assign pos_word = ADDR_W'(pos >> WORD_LOG);
  assign pos_bit  = pos[WORD_LOG-1:0];
  assign rd_data  = rd_ok ? rd_word : '0;

  assign rd_en   = cmd.accept | cmd.scan_rd;
  assign rd_addr = cmd.accept ? ADDR_W'(pos_in >> WORD_LOG) : cmd.scan_addr;

  assign removed_bit = rd_data[pos_bit];
  assign rej_now     = (32'(pos) > 32'(eff_top)) | removed_bit;

  assign status.pipe_busy = scan_v | sum_v;
  assign status.out_free  = !out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
    if (cmd.update && !rej_now) begin
      mem[pos_word] <= rd_data | (WORD_W'(1) << pos_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
      top       <= TOP_RESET;
      scan_v    <= 1'b0;
      sum_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
      if (cmd.update && !rej_now) begin
        row_valid[pos_word] <= 1'b1;
      end
      if (cfg_we) begin
        top <= cfg_top;
      end
      scan_v <= cmd.scan_rd;
      sum_v  <= scan_v;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Positions above the range count as removed.
  always_comb begin
    above = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (rd_addr_q > ADDR_W'(eff_top >> WORD_LOG)) begin
        above[i] = 1'b1;
      end else if (rd_addr_q == ADDR_W'(eff_top >> WORD_LOG)) begin
        above[i] = (WORD_LOG'(i) > eff_top[WORD_LOG-1:0]);
      end
    end
  end

  assign free_bits = ~(rd_data | above);

  // Log-depth tree of segment summaries over one word.
  always_comb begin
    for (int l = 0; l <= WORD_LOG; l++) begin
      for (int j = 0; j < WORD_W; j++) begin
        tree[l][j] = '0;
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      tree[0][j].full = free_bits[j];
      tree[0][j].pre  = SEG_W'(free_bits[j]);
      tree[0][j].suf  = SEG_W'(free_bits[j]);
      tree[0][j].best = SEG_W'(free_bits[j]);
    end
    for (int l = 1; l <= WORD_LOG; l++) begin
      for (int j = 0; j < WORD_W / 2; j++) begin
        if (j < (WORD_W >> l)) begin
          tree[l][j] = seg_join(tree[l-1][2*j], tree[l-1][2*j+1]);
        end
      end
    end
    word_seg = tree[WORD_LOG][0];
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    if (scan_v) begin
      summary <= word_seg;
    end
  end

  // Fold one word summary into the running run and best.
  always_comb begin
    cand  = RUN_W'(cur + RUN_W'(summary.pre));
    wbest = RUN_W'(summary.best);
    if (summary.full) begin
      cur_next  = RUN_W'(cur + RUN_W'(WORD_W));
      best_next = (cur_next > best) ? cur_next : best;
    end else begin
      cur_next  = RUN_W'(summary.suf);
      best_next = best;
      if (cand > best_next) begin
        best_next = cand;
      end
      if (wbest > best_next) begin
        best_next = wbest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos  <= pos_in;
      cur  <= '0;
      best <= '0;
    end else if (sum_v) begin
      cur  <= cur_next;
      best <= best_next;
    end
    if (cmd.update) begin
      rej <= rej_now;
    end
    if (cmd.load_out) begin
      out_run <= best;
      out_rej <= rej;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/longest_free_run_tracker_unit.sv
// Top level of the longest free run tracker: joins controller and datapath.
// Depends on lfrt_pkg, lfrt_ctrl and lfrt_datapath.
//
// Usage: each request on the slave stream names one position (s_tdata[9:0])
// to remove from the range 0 through top_value. The block answers every
// request with one result on the master stream: the length of the longest
// run of consecutive positions still present (m_tdata[10:0]) and a reject
// flag (m_tuser), raised when the position lies above top_value or was
// already removed; a rejected request leaves the map unchanged.
// top_value is to be written through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Each request is checked
// against the bitmap word read at acceptance, which is then updated; next,
// every 32-bit word of the bitmap memory is read through its single read
// port, the last word is summarized and folded, and the result is loaded
// into the output register. The block takes the next request only after
// that load, in the idle state; a new request is taken while the previous
// result still waits on the master side.
// If the receiver stalls, the result holds in the output register and the
// next request finishes its scan, then waits until the register frees.
// Reset clears the bitmap through per-word valid flags, sets top_value to
// 1023 and drops m_tvalid.
`default_nettype none

module longest_free_run_tracker_unit
  import lfrt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [DATA_IN_W-1:0]  s_tdata,   // [9:0] position
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [DATA_OUT_W-1:0]      m_tdata,   // [10:0] longest_run
  output logic                       m_tuser,   // [0] rejected
  input  wire logic                  cfg_we,
  input  wire logic [TOP_W-1:0]      cfg_wdata
);

  lfrt_cmd_t        cmd;
  lfrt_status_t     status;
  logic [RUN_W-1:0] run;

  lfrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lfrt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .pos_in    (s_tdata[POS_W-1:0]),
    .cfg_we    (cfg_we),
    .cfg_top   (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_run   (run),
    .out_rej   (m_tuser)
  );

  // Upper bits of the input request are padding and not used.
  assign m_tdata = DATA_OUT_W'(run);

endmodule

`default_nettype wire

>>> hw/rtl/lfrt_checker.sv
// Port-level checker for the longest free run tracker, bound to the top level.
// Depends on lfrt_pkg.
`default_nettype none

module lfrt_checker
  import lfrt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [DATA_OUT_W-1:0] m_tdata,
  input wire logic                  m_tuser
);

  // One request at a time: no new request right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken twice in a row");

  // A run never exceeds the number of positions.
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[RUN_W-1:0] <= RUN_W'(MAX_POSITIONS)))
    else $error("longest run out of range");

  // A result cannot appear right after a request when none was pending.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Reset drops the output.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind longest_free_run_tracker_unit lfrt_checker u_lfrt_checker (.*);

`default_nettype wire

>>> sim/longest_free_run_tracker_unit_tb.sv
// Self-checking testbench for longest_free_run_tracker_unit: removes positions
// over the request stream and checks every run length and reject flag.
// Depends on lfrt_pkg and the RTL of the tracker; reads no files.
`default_nettype none

module longest_free_run_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrt_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int IDLE_PCT      = 21;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 65;
  // The tail wait is longer than the time the block takes to answer a request.
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic {
    ROW_REMOVE,
    ROW_SET_TOP
  } row_kind_t;

  // One row of the directed plan. When typed is set, run and rejected hold
  // the answer written by hand; otherwise the predictor supplies it.
  typedef struct packed {
    row_kind_t        kind;
    logic [POS_W-1:0] value;
    logic             typed;
    logic [RUN_W-1:0] run;
    logic             rejected;
  } plan_row_t;

  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic             rejected;
  } run_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [DATA_IN_W-1:0]  s_tdata;   // [9:0] position
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_OUT_W-1:0] m_tdata;   // [10:0] longest_run
  logic                  m_tuser;   // [0] rejected
  logic                  cfg_we;
  logic [TOP_W-1:0]      cfg_wdata;

  // Predictor state: which positions are gone and the current top of range.
  bit               gone_map [MAX_POSITIONS];
  logic [TOP_W-1:0] range_top;
  run_result_t      pending_results [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  // While set, neither side inserts idle cycles.
  bit               steady = 1'b0;

  // The directed plan walks the corners: both ends of the range, a repeated
  // removal, a range of a single position, positions above the range, a
  // range where every position ends up removed, and growing the range back
  // so that marks above the old top count again.
  plan_row_t directed_plan [23] = '{
    '{ROW_REMOVE,  10'd0,    1'b1, 11'd1023, 1'b0},
    '{ROW_REMOVE,  10'd1023, 1'b1, 11'd1022, 1'b0},
    '{ROW_REMOVE,  10'd0,    1'b1, 11'd1022, 1'b1},
    '{ROW_REMOVE,  10'd512,  1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd1,    1'b0, 11'd0,    1'b0},
    '{ROW_SET_TOP, 10'd0,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd0,    1'b1, 11'd0,    1'b1},
    '{ROW_REMOVE,  10'd1023, 1'b1, 11'd0,    1'b1},
    '{ROW_REMOVE,  10'd1,    1'b1, 11'd0,    1'b1},
    '{ROW_SET_TOP, 10'd7,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd8,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd4,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd2,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd3,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd5,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd6,    1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd7,    1'b1, 11'd0,    1'b0},
    '{ROW_SET_TOP, 10'd1023, 1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd1023, 1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd682,  1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd341,  1'b0, 11'd0,    1'b0},
    '{ROW_SET_TOP, 10'd1022, 1'b0, 11'd0,    1'b0},
    '{ROW_REMOVE,  10'd1023, 1'b0, 11'd0,    1'b0}
  };

  longest_free_run_tracker_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Longest stretch of positions still present within 0 through range_top.
  function automatic logic [RUN_W-1:0] longest_present();
    int streak = 0;
    int best   = 0;
    for (int i = 0; i <= int'(range_top) && i < MAX_POSITIONS; i++) begin
      if (gone_map[i]) begin
        streak = 0;
      end else begin
        streak++;
        if (streak > best) best = streak;
      end
    end
    return RUN_W'(best);
  endfunction

  // Applies one removal to the predictor and returns the answer it expects.
  // A position above the range or one already gone leaves the map alone.
  function automatic run_result_t remove_position(input logic [POS_W-1:0] pos);
    run_result_t r;
    r.rejected = (pos > range_top) || gone_map[pos];
    if (!r.rejected) gone_map[pos] = 1'b1;
    r.run = longest_present();
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offers one request, holding it until the block takes it. The expected
  // answer is queued at the acceptance edge, so the predictor sees requests
  // in exactly the order the block does.
  task automatic send_position(input logic [POS_W-1:0] pos, input bit typed,
                               input run_result_t typed_result);
    run_result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(DATA_IN_W-POS_W){1'b0}}, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = remove_position(pos);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // The range may only change while the block is idle, so the sender drains
  // every outstanding answer first. Every result arriving means every
  // request is finished, since each request produces exactly one.
  task automatic set_top(input logic [TOP_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    range_top = value;
  endtask

  // Result side: compares each accepted answer with the oldest expectation,
  // then picks the ready level for the next edge.
  always @(posedge clk) begin : result_check
    run_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: run=%0d rejected=%0b",
                                m_tdata[RUN_W-1:0], m_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[RUN_W-1:0] !== want.run)
          note_mismatch($sformatf("longest_run got %0d want %0d",
                                  m_tdata[RUN_W-1:0], want.run));
        if (m_tuser !== want.rejected)
          note_mismatch($sformatf("rejected got %0b want %0b", m_tuser, want.rejected));
      end
    end
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    run_result_t      typed_result;
    logic [TOP_W-1:0] phase_top;
    logic [POS_W-1:0] pos;
    int               roll;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= TOP_RESET;
    range_top = TOP_RESET;
    foreach (gone_map[i]) gone_map[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_SET_TOP) begin
        set_top(directed_plan[i].value);
      end else begin
        typed_result.run      = directed_plan[i].run;
        typed_result.rejected = directed_plan[i].rejected;
        send_position(directed_plan[i].value, directed_plan[i].typed, typed_result);
      end
    end

    // Random phases. Each one picks a range, drains and writes it, then
    // mostly removes positions inside the range so that the map keeps
    // filling up; the rest land above the range or anywhere at all.
    // Removals persist across phases, so repeats get rejected more and more.
    for (int phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 4) || (phase == 5);
      case (phase % 4)
        0: begin
          phase_top = TOP_W'(MAX_TOP);
        end
        1: begin
          phase_top = TOP_W'($urandom_range(0, MAX_TOP));
        end
        2: begin
          phase_top = TOP_W'($urandom_range(0, 63));
        end
        default: begin
          phase_top = TOP_W'($urandom_range(512, MAX_TOP));
        end
      endcase
      set_top(phase_top);
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 80)
          pos = POS_W'($urandom_range(0, int'(phase_top)));
        else if (roll < 90 && int'(phase_top) != MAX_TOP)
          pos = POS_W'($urandom_range(int'(phase_top) + 1, MAX_TOP));
        else
          pos = POS_W'($urandom_range(0, MAX_TOP));
        send_position(pos, 1'b0, '0);
      end
    end
    steady = 1'b0;

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
